// ----- rtl/bfsm_pkg.sv -----
// ----------------------------------------------------------------------------
// bfsm_pkg: shared definitions of the tape language step machine
// Sizes, command and instruction codes, error codes and the symbol decoder.
// ----------------------------------------------------------------------------
package bfsm_pkg;

  localparam int PROG_DEPTH = 1024;
  localparam int TAPE_CELLS = 4096;
  localparam int LOOP_DEPTH = 64;

  localparam int PROG_AW = $clog2(PROG_DEPTH);
  localparam int PC_W    = $clog2(PROG_DEPTH + 1);
  localparam int TAPE_AW = $clog2(TAPE_CELLS);
  localparam int LOOP_AW = $clog2(LOOP_DEPTH);
  localparam int LD_W    = $clog2(LOOP_DEPTH + 1);

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_EXEC  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [2:0] OP_INC   = 3'd0;
  localparam logic [2:0] OP_DEC   = 3'd1;
  localparam logic [2:0] OP_RIGHT = 3'd2;
  localparam logic [2:0] OP_LEFT  = 3'd3;
  localparam logic [2:0] OP_OUT   = 3'd4;
  localparam logic [2:0] OP_IN    = 3'd5;
  localparam logic [2:0] OP_OPEN  = 3'd6;
  localparam logic [2:0] OP_CLOSE = 3'd7;

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_OPEN_CLOSE = 3'd1;
  localparam logic [2:0] ERR_OPEN_SCAN  = 3'd2;
  localparam logic [2:0] ERR_STACK_FULL = 3'd3;
  localparam logic [2:0] ERR_PROG_FULL  = 3'd4;

  typedef struct packed {
    logic       ok;
    logic [2:0] op;
  } sym_t;

  function automatic sym_t sym_decode(input logic [7:0] s);
    sym_t d;
    d.ok = 1'b1;
    case (s)
      8'h2B: d.op = OP_INC;
      8'h2D: d.op = OP_DEC;
      8'h3E: d.op = OP_RIGHT;
      8'h3C: d.op = OP_LEFT;
      8'h2E: d.op = OP_OUT;
      8'h2C: d.op = OP_IN;
      8'h5B: d.op = OP_OPEN;
      8'h5D: d.op = OP_CLOSE;
      default: begin
        d.ok = 1'b0;
        d.op = OP_INC;
      end
    endcase
    return d;
  endfunction

endpackage

// ----- rtl/bfsm_in_if.sv -----
// ----------------------------------------------------------------------------
// bfsm_in_if: command channel
// Valid/ready channel carrying one command beat with its symbol and byte.
// ----------------------------------------------------------------------------
interface bfsm_in_if import bfsm_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] symbol;
  logic [7:0] input_byte;

  modport source (output valid, output command, output symbol, output input_byte,
                  input ready);
  modport sink (input valid, input command, input symbol, input input_byte,
                output ready);
endinterface

// ----- rtl/bfsm_out_if.sv -----
// ----------------------------------------------------------------------------
// bfsm_out_if: result channel
// Valid/ready channel carrying one status beat per command.
// ----------------------------------------------------------------------------
interface bfsm_out_if import bfsm_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       halted;
  logic [2:0] error_code;

  modport source (output valid, output out_valid, output out_byte, output halted,
                  output error_code, input ready);
  modport sink (input valid, input out_valid, input out_byte, input halted,
                input error_code, output ready);
endinterface

// ----- rtl/bfsm_ram.sv -----
// ----------------------------------------------------------------------------
// bfsm_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bfsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/brainfuck_step_machine.sv -----
// ----------------------------------------------------------------------------
// brainfuck_step_machine: step machine for the eight-instruction tape language
// Loads program symbols, runs one instruction per execute beat and reports
// the output byte and machine status with one result beat per command.
// ----------------------------------------------------------------------------
// Each command beat yields one result beat. A load, an unused command or an
// execute while halted goes straight to the response. An instruction is
// fetched from the program and tape memories, executed and answered; a loop
// close that jumps back passes a pop state, as the jump target is taken from
// the loop stack in a cycle of its own, and a loop open on a zero cell scans
// the program memory, whose read is registered, with a read and a check
// state per symbol, ending in an error if no matching close is found. After
// reset and on every clear command the tape memory is zeroed one cell per
// cycle over all 4096 cells, during which no command is accepted; the clear
// command's result follows that pass. Ready is low while a command is in
// work; a result waits in an output register until it is taken.
// ----------------------------------------------------------------------------
module brainfuck_step_machine import bfsm_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  bfsm_in_if.sink    in_if,
  bfsm_out_if.source out_if
);

  localparam logic [2:0] S_CLEAR    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_EXEC     = 3'd2;
  localparam logic [2:0] S_SCAN_RD  = 3'd3;
  localparam logic [2:0] S_SCAN_CHK = 3'd4;
  localparam logic [2:0] S_POP      = 3'd5;
  localparam logic [2:0] S_RESP     = 3'd6;

  localparam logic [TAPE_AW-1:0] TAPE_LAST = TAPE_AW'(TAPE_CELLS - 1);
  localparam logic [LD_W-1:0]    LOOP_FULL = LD_W'(LOOP_DEPTH);

  logic [2:0]         state_r, state_nxt;
  logic [PC_W-1:0]    len_r, len_nxt;
  logic [PC_W-1:0]    pc_r, pc_nxt;
  logic [TAPE_AW-1:0] cp_r, cp_nxt;
  logic [LD_W-1:0]    depth_r, depth_nxt;
  logic [2:0]         err_r, err_nxt;
  logic [PC_W-1:0]    k_r, k_nxt;
  logic [PC_W-1:0]    nest_r, nest_nxt;
  logic [TAPE_AW-1:0] clr_addr_r, clr_addr_nxt;
  logic               clr_resp_r, clr_resp_nxt;
  logic [7:0]         inb_r, inb_nxt;
  logic               emit_r, emit_nxt;
  logic [7:0]         byte_r, byte_nxt;
  logic               ovld_r, ovld_nxt;
  logic               o_emit_r, o_emit_nxt;
  logic [7:0]         o_byte_r, o_byte_nxt;
  logic               o_halt_r, o_halt_nxt;
  logic [2:0]         o_err_r, o_err_nxt;

  logic               prog_we;
  logic [PROG_AW-1:0] prog_waddr;
  logic [2:0]         prog_wdata;
  logic [PROG_AW-1:0] prog_raddr;
  logic [2:0]         prog_rdata;

  logic               tape_we;
  logic [TAPE_AW-1:0] tape_waddr;
  logic [7:0]         tape_wdata;
  logic [7:0]         tape_rdata;

  logic               loop_we;
  logic [LOOP_AW-1:0] loop_waddr;
  logic [LOOP_AW-1:0] loop_raddr;
  logic [PROG_AW-1:0] loop_rdata;

  logic       in_beat;
  logic       halted_now;
  logic [2:0] raise_code;
  logic       raise;
  sym_t       sym;

  assign in_if.ready = (state_r == S_IDLE) && (!ovld_r || out_if.ready);
  assign in_beat     = in_if.valid && in_if.ready;
  assign halted_now  = (err_r != ERR_NONE) || (pc_r >= len_r);
  assign sym         = sym_decode(in_if.symbol);

  assign out_if.valid      = ovld_r;
  assign out_if.out_valid  = o_emit_r;
  assign out_if.out_byte   = o_byte_r;
  assign out_if.halted     = o_halt_r;
  assign out_if.error_code = o_err_r;

  assign prog_waddr = len_r[PROG_AW-1:0];
  assign prog_wdata = sym.op;
  assign loop_waddr = depth_r[LOOP_AW-1:0];
  assign loop_raddr = LOOP_AW'(depth_r - LD_W'(1));

  always_comb begin
    state_nxt    = state_r;
    len_nxt      = len_r;
    pc_nxt       = pc_r;
    cp_nxt       = cp_r;
    depth_nxt    = depth_r;
    k_nxt        = k_r;
    nest_nxt     = nest_r;
    clr_addr_nxt = clr_addr_r;
    clr_resp_nxt = clr_resp_r;
    inb_nxt      = inb_r;
    emit_nxt     = emit_r;
    byte_nxt     = byte_r;
    ovld_nxt     = ovld_r;
    o_emit_nxt   = o_emit_r;
    o_byte_nxt   = o_byte_r;
    o_halt_nxt   = o_halt_r;
    o_err_nxt    = o_err_r;
    raise        = 1'b0;
    raise_code   = ERR_NONE;
    prog_we      = 1'b0;
    prog_raddr   = pc_r[PROG_AW-1:0];
    tape_we      = 1'b0;
    tape_waddr   = cp_r;
    tape_wdata   = 8'd0;
    loop_we      = 1'b0;

    if (ovld_r && out_if.ready) begin
      ovld_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        tape_we      = 1'b1;
        tape_waddr   = clr_addr_r;
        clr_addr_nxt = clr_addr_r + TAPE_AW'(1);
        if (clr_addr_r == TAPE_LAST) begin
          state_nxt = clr_resp_r ? S_RESP : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_beat) begin
          emit_nxt  = 1'b0;
          byte_nxt  = 8'd0;
          inb_nxt   = in_if.input_byte;
          state_nxt = S_RESP;
          case (in_if.command)
            CMD_LOAD: begin
              if (sym.ok) begin
                if (len_r >= PC_W'(PROG_DEPTH)) begin
                  raise      = 1'b1;
                  raise_code = ERR_PROG_FULL;
                end else begin
                  prog_we = 1'b1;
                  len_nxt = len_r + PC_W'(1);
                end
              end
            end
            CMD_EXEC: begin
              if (!halted_now) begin
                state_nxt = S_EXEC;
              end
            end
            CMD_CLEAR: begin
              len_nxt      = '0;
              pc_nxt       = '0;
              cp_nxt       = '0;
              depth_nxt    = '0;
              clr_addr_nxt = '0;
              clr_resp_nxt = 1'b1;
              state_nxt    = S_CLEAR;
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_EXEC: begin
        state_nxt = S_RESP;
        pc_nxt    = pc_r + PC_W'(1);
        case (prog_rdata)
          OP_INC: begin
            tape_we    = 1'b1;
            tape_wdata = tape_rdata + 8'd1;
          end
          OP_DEC: begin
            tape_we    = 1'b1;
            tape_wdata = tape_rdata - 8'd1;
          end
          OP_RIGHT: begin
            cp_nxt = (cp_r == TAPE_LAST) ? '0 : cp_r + TAPE_AW'(1);
          end
          OP_LEFT: begin
            cp_nxt = (cp_r == '0) ? TAPE_LAST : cp_r - TAPE_AW'(1);
          end
          OP_OUT: begin
            emit_nxt = 1'b1;
            byte_nxt = tape_rdata;
          end
          OP_IN: begin
            tape_we    = 1'b1;
            tape_wdata = inb_r;
          end
          OP_OPEN: begin
            if (tape_rdata != 8'd0) begin
              if (depth_r >= LOOP_FULL) begin
                raise      = 1'b1;
                raise_code = ERR_STACK_FULL;
                pc_nxt     = pc_r;
              end else begin
                loop_we   = 1'b1;
                depth_nxt = depth_r + LD_W'(1);
              end
            end else begin
              pc_nxt    = pc_r;
              k_nxt     = pc_r + PC_W'(1);
              nest_nxt  = '0;
              state_nxt = S_SCAN_RD;
            end
          end
          default: begin
            if (depth_r == '0) begin
              raise      = 1'b1;
              raise_code = ERR_OPEN_CLOSE;
              pc_nxt     = pc_r;
            end else if (tape_rdata != 8'd0) begin
              pc_nxt    = pc_r;
              state_nxt = S_POP;
            end else begin
              depth_nxt = depth_r - LD_W'(1);
            end
          end
        endcase
      end
      S_SCAN_RD: begin
        if (k_r >= len_r) begin
          raise      = 1'b1;
          raise_code = ERR_OPEN_SCAN;
          state_nxt  = S_RESP;
        end else begin
          prog_raddr = k_r[PROG_AW-1:0];
          state_nxt  = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        k_nxt     = k_r + PC_W'(1);
        state_nxt = S_SCAN_RD;
        if (prog_rdata == OP_OPEN) begin
          nest_nxt = nest_r + PC_W'(1);
        end else if (prog_rdata == OP_CLOSE) begin
          if (nest_r == '0) begin
            pc_nxt    = k_r + PC_W'(1);
            state_nxt = S_RESP;
          end else begin
            nest_nxt = nest_r - PC_W'(1);
          end
        end
      end
      S_POP: begin
        pc_nxt    = PC_W'(loop_rdata) + PC_W'(1);
        state_nxt = S_RESP;
      end
      S_RESP: begin
        ovld_nxt     = 1'b1;
        o_emit_nxt   = emit_r;
        o_byte_nxt   = byte_r;
        o_halt_nxt   = halted_now;
        o_err_nxt    = err_r;
        clr_resp_nxt = 1'b0;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    err_nxt = err_r;
    if (raise && (err_r == ERR_NONE)) begin
      err_nxt = raise_code;
    end
    if ((state_r == S_IDLE) && in_beat && (in_if.command == CMD_CLEAR)) begin
      err_nxt = ERR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      len_r      <= '0;
      pc_r       <= '0;
      cp_r       <= '0;
      depth_r    <= '0;
      err_r      <= ERR_NONE;
      clr_addr_r <= '0;
      clr_resp_r <= 1'b0;
      ovld_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      len_r      <= len_nxt;
      pc_r       <= pc_nxt;
      cp_r       <= cp_nxt;
      depth_r    <= depth_nxt;
      err_r      <= err_nxt;
      clr_addr_r <= clr_addr_nxt;
      clr_resp_r <= clr_resp_nxt;
      ovld_r     <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r      <= k_nxt;
    nest_r   <= nest_nxt;
    inb_r    <= inb_nxt;
    emit_r   <= emit_nxt;
    byte_r   <= byte_nxt;
    o_emit_r <= o_emit_nxt;
    o_byte_r <= o_byte_nxt;
    o_halt_r <= o_halt_nxt;
    o_err_r  <= o_err_nxt;
  end

  bfsm_ram #(.WIDTH(3), .DEPTH(PROG_DEPTH)) u_prog (
    .clk   (clk),
    .we    (prog_we),
    .waddr (prog_waddr),
    .wdata (prog_wdata),
    .raddr (prog_raddr),
    .rdata (prog_rdata)
  );

  bfsm_ram #(.WIDTH(8), .DEPTH(TAPE_CELLS)) u_tape (
    .clk   (clk),
    .we    (tape_we),
    .waddr (tape_waddr),
    .wdata (tape_wdata),
    .raddr (cp_r),
    .rdata (tape_rdata)
  );

  bfsm_ram #(.WIDTH(PROG_AW), .DEPTH(LOOP_DEPTH)) u_loop (
    .clk   (clk),
    .we    (loop_we),
    .waddr (loop_waddr),
    .wdata (pc_r[PROG_AW-1:0]),
    .raddr (loop_raddr),
    .rdata (loop_rdata)
  );

endmodule
